/* hw/rtl/csvrp_pkg.sv */
// Shared types, codes and constants for the typed CSV row parser.
package csvrp_pkg;

   // Schema limits
   localparam int MAX_COLUMNS = 64;
   localparam int COL_W       = 6;
   localparam int COUNT_W     = 7;

   // Result queue depth (two results may enter per byte)
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_IS_TEXT = 1'd1;

   // Result kinds
   localparam logic [2:0] KIND_TEXT = 3'd0;
   localparam logic [2:0] KIND_TEND = 3'd1;
   localparam logic [2:0] KIND_INT  = 3'd2;
   localparam logic [2:0] KIND_DONE = 3'd3;
   localparam logic [2:0] KIND_ERR  = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_EMPTY    = 3'd0;
   localparam logic [2:0] ERR_INVALID  = 3'd1;
   localparam logic [2:0] ERR_UNQUOTED = 3'd2;
   localparam logic [2:0] ERR_UNTERM   = 3'd3;
   localparam logic [2:0] ERR_WIDTH    = 3'd4;

   // Parser modes
   localparam logic [2:0] MODE_BLANK0 = 3'd0;
   localparam logic [2:0] MODE_BLANK1 = 3'd1;
   localparam logic [2:0] MODE_INT    = 3'd2;
   localparam logic [2:0] MODE_TOPEN  = 3'd3;
   localparam logic [2:0] MODE_TIN    = 3'd4;
   localparam logic [2:0] MODE_TQUOTE = 3'd5;
   localparam logic [2:0] MODE_TRAIL  = 3'd6;
   localparam logic [2:0] MODE_DEAD   = 3'd7;

   // Integer scan phases
   localparam logic [1:0] PH_WS     = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;

   // Characters
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [3:0] RADIX      = 4'd10;

   // Saturation limits
   localparam logic [63:0] INT_MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_MIN_MAG = 64'h8000_0000_0000_0000;

   // Input item
   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_last;
   } req_type;

   // Result item
   typedef struct packed {
      logic [2:0]         item_kind;
      logic [COL_W-1:0]   column;
      logic [7:0]         text_byte;
      logic signed [63:0] int_result;
      logic [2:0]         error_code;
      logic               run_last;
   } rsp_type;

endpackage

/* hw/rtl/csv_typed_row_parser_top.sv */
// Typed CSV row parser: one line byte per item in, text/integer/row/error items out.
// A result is written into the result queue when its byte is accepted and is offered on rsp from there.
// Throughput: one byte per cycle while results drain; the output takes one result
// per cycle, so bytes that give two results can fill the queue faster than it drains. req_stall
// rises when the four-entry result queue has fewer than two free entries.
// Reset (synchronous): parser back at line start, queue empty, configuration registers zero.
module csv_typed_row_parser_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  csvrp_pkg::req_type                     req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output csvrp_pkg::rsp_type                     rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [csvrp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [63:0]                            csr_data
);

   typedef struct packed {
      logic        ok;
      logic [2:0]  err;
      logic [63:0] val;
   } fin_type;

   // Build one result item
   function automatic csvrp_pkg::rsp_type mk(input logic [2:0] kind,
                                             input logic [csvrp_pkg::COL_W-1:0] col,
                                             input logic [7:0] tb,
                                             input logic [63:0] val,
                                             input logic [2:0] err);
      csvrp_pkg::rsp_type r;
      r.item_kind  = kind;
      r.column     = col;
      r.text_byte  = tb;
      r.int_result = val;
      r.error_code = err;
      r.run_last   = 1'b0;
      return r;
   endfunction

   // Append a result; anything past two is dropped
   function automatic void push(inout csvrp_pkg::rsp_type r0, inout csvrp_pkg::rsp_type r1,
                                inout logic [1:0] n, input csvrp_pkg::rsp_type x);
      if (n == 2'd0) begin
         r0 = x;
         n  = 2'd1;
      end else if (n == 2'd1) begin
         r1 = x;
         n  = 2'd2;
      end
   endfunction

   // Close an integer field: check shape, then saturate and apply sign
   function automatic fin_type int_fin(input logic ne, input logic bad, input logic [1:0] ph,
                                       input logic neg, input logic ovf,
                                       input logic [63:0] mag);
      fin_type f;
      f.ok  = 1'b0;
      f.err = csvrp_pkg::ERR_EMPTY;
      f.val = '0;
      if (!ne) begin
         f.err = csvrp_pkg::ERR_EMPTY;
      end else if (bad || ph != csvrp_pkg::PH_DIGITS) begin
         f.err = csvrp_pkg::ERR_INVALID;
      end else begin
         f.ok = 1'b1;
         if (neg) begin
            if (ovf || mag > csvrp_pkg::INT_MIN_MAG) begin
               f.val = csvrp_pkg::INT_MIN_MAG;
            end else begin
               f.val = 64'd0 - mag;
            end
         end else begin
            if (ovf || mag > csvrp_pkg::INT_MAX_MAG) begin
               f.val = csvrp_pkg::INT_MAX_MAG;
            end else begin
               f.val = mag;
            end
         end
      end
      return f;
   endfunction

   // Configuration
   logic [csvrp_pkg::COUNT_W-1:0] count_ff;
   logic [63:0]                   text_ff;

   // Line state
   logic [2:0]                    mode_ff, mode_in;
   logic [csvrp_pkg::COL_W-1:0]   col_ff, col_in;
   logic [63:0]                   mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [1:0]                    ph_ff, ph_in;
   logic                          ovf_ff, ovf_in;
   logic                          bad_ff, bad_in;
   logic                          ne_ff, ne_in;

   // Result queue
   csvrp_pkg::rsp_type                fifo_ff [csvrp_pkg::FIFO_DEPTH];
   logic [csvrp_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [csvrp_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [csvrp_pkg::FIFO_CNT_W-1:0]  fifo_cnt_ff, fifo_cnt_in;

   logic                          req_accept;
   logic                          rsp_pop;
   logic [csvrp_pkg::COUNT_W-1:0] eff_count;
   csvrp_pkg::rsp_type            res0, res1;
   logic [1:0]                    res_n;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign req_stall  = fifo_cnt_ff >
                       csvrp_pkg::FIFO_CNT_W'(csvrp_pkg::FIFO_DEPTH - 2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = fifo_cnt_ff != '0;
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   // Column counts above the limit act as the limit
   assign eff_count = (count_ff > csvrp_pkg::COUNT_W'(csvrp_pkg::MAX_COLUMNS)) ?
                      csvrp_pkg::COUNT_W'(csvrp_pkg::MAX_COLUMNS) : count_ff;

   // Parse one byte: state update and up to two results
   always_comb begin
      logic [7:0]  b;
      logic        crlf;
      logic        digit;
      logic        more;
      logic        do_field;
      logic        field_done;
      logic [67:0] prod;
      fin_type     fin;

      b          = req_payload.line_byte;
      crlf       = (b == csvrp_pkg::CHAR_CR) || (b == csvrp_pkg::CHAR_LF);
      digit      = (b >= csvrp_pkg::CHAR_ZERO) && (b <= csvrp_pkg::CHAR_NINE);
      more       = 1'b0;
      do_field   = 1'b0;
      field_done = 1'b0;
      prod       = '0;
      fin        = '0;

      mode_in = mode_ff;
      col_in  = col_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      ph_in   = ph_ff;
      ovf_in  = ovf_ff;
      bad_in  = bad_ff;
      ne_in   = ne_ff;
      res0    = '0;
      res1    = '0;
      res_n   = 2'd0;

      if (req_accept) begin
         // Line start: skip CR/LF; data opens column zero, or errs with no columns or after CR/LF
         if (mode_ff == csvrp_pkg::MODE_BLANK0 || mode_ff == csvrp_pkg::MODE_BLANK1) begin
            if (crlf) begin
               mode_in = csvrp_pkg::MODE_BLANK1;
            end else if (eff_count == '0) begin
               col_in  = '0;
               push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, '0, 8'd0, 64'd0,
                                          csvrp_pkg::ERR_WIDTH));
               mode_in = csvrp_pkg::MODE_DEAD;
            end else if (mode_ff == csvrp_pkg::MODE_BLANK1) begin
               col_in  = '0;
               push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, '0, 8'd0, 64'd0,
                                          text_ff[0] ? csvrp_pkg::ERR_UNQUOTED :
                                                       csvrp_pkg::ERR_EMPTY));
               mode_in = csvrp_pkg::MODE_DEAD;
            end else begin
               col_in   = '0;
               mag_in   = '0;
               neg_in   = 1'b0;
               ph_in    = csvrp_pkg::PH_WS;
               ovf_in   = 1'b0;
               bad_in   = 1'b0;
               ne_in    = 1'b0;
               mode_in  = text_ff[0] ? csvrp_pkg::MODE_TOPEN : csvrp_pkg::MODE_INT;
               do_field = 1'b1;
            end
         end else begin
            do_field = 1'b1;
         end

         // Field byte
         if (do_field) begin
            unique case (mode_in)
               csvrp_pkg::MODE_INT: begin
                  if (b == csvrp_pkg::CHAR_COMMA || crlf) begin
                     fin = int_fin(ne_in, bad_in, ph_in, neg_in, ovf_in, mag_in);
                     if (fin.ok) begin
                        push(res0, res1, res_n, mk(csvrp_pkg::KIND_INT, col_in, 8'd0,
                                                   fin.val, 3'd0));
                        field_done = 1'b1;
                     end else begin
                        push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0,
                                                   64'd0, fin.err));
                        mode_in = csvrp_pkg::MODE_DEAD;
                     end
                  end else begin
                     ne_in = 1'b1;
                     if (!bad_in) begin
                        if (ph_in == csvrp_pkg::PH_WS &&
                            (b == csvrp_pkg::CHAR_SPACE || b == csvrp_pkg::CHAR_TAB ||
                             b == csvrp_pkg::CHAR_VT || b == csvrp_pkg::CHAR_FF)) begin
                           ph_in = csvrp_pkg::PH_WS;
                        end else if (ph_in == csvrp_pkg::PH_WS &&
                                     (b == csvrp_pkg::CHAR_PLUS ||
                                      b == csvrp_pkg::CHAR_MINUS)) begin
                           neg_in = (b == csvrp_pkg::CHAR_MINUS);
                           ph_in  = csvrp_pkg::PH_SIGN;
                        end else if (!digit) begin
                           bad_in = 1'b1;
                        end else begin
                           ph_in = csvrp_pkg::PH_DIGITS;
                           // Multiply by ten and add the digit; carry out means overflow
                           prod  = ({4'd0, mag_in} << 3) + ({4'd0, mag_in} << 1) +
                                   68'(b - csvrp_pkg::CHAR_ZERO);
                           if (!ovf_in) begin
                              if (prod[67:64] != 4'd0) begin
                                 ovf_in = 1'b1;
                              end else begin
                                 mag_in = prod[63:0];
                              end
                           end
                        end
                     end
                  end
               end
               csvrp_pkg::MODE_TOPEN: begin
                  if (b == csvrp_pkg::CHAR_QUOTE) begin
                     mode_in = csvrp_pkg::MODE_TIN;
                  end else begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                                csvrp_pkg::ERR_UNQUOTED));
                     mode_in = csvrp_pkg::MODE_DEAD;
                  end
               end
               csvrp_pkg::MODE_TIN: begin
                  if (b == csvrp_pkg::CHAR_QUOTE) begin
                     mode_in = csvrp_pkg::MODE_TQUOTE;
                  end else begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_TEXT, col_in, b, 64'd0,
                                                3'd0));
                  end
               end
               csvrp_pkg::MODE_TQUOTE: begin
                  // Doubled quote stays text; anything else closes the field
                  if (b == csvrp_pkg::CHAR_QUOTE) begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_TEXT, col_in,
                                                csvrp_pkg::CHAR_QUOTE, 64'd0, 3'd0));
                     mode_in = csvrp_pkg::MODE_TIN;
                  end else begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_TEND, col_in, 8'd0,
                                                64'd0, 3'd0));
                     field_done = 1'b1;
                  end
               end
               csvrp_pkg::MODE_TRAIL: begin
                  if (!crlf) begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                                csvrp_pkg::ERR_WIDTH));
                     mode_in = csvrp_pkg::MODE_DEAD;
                  end
               end
               default: begin
               end
            endcase
         end

         // Separator or line end after a completed field
         if (field_done) begin
            more = ({1'b0, col_in} + 7'd1) < eff_count;
            if (more) begin
               if (b == csvrp_pkg::CHAR_COMMA) begin
                  col_in  = col_in + csvrp_pkg::COL_W'(1);
                  mag_in  = '0;
                  neg_in  = 1'b0;
                  ph_in   = csvrp_pkg::PH_WS;
                  ovf_in  = 1'b0;
                  bad_in  = 1'b0;
                  ne_in   = 1'b0;
                  mode_in = text_ff[col_in] ? csvrp_pkg::MODE_TOPEN : csvrp_pkg::MODE_INT;
               end else begin
                  push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                             csvrp_pkg::ERR_WIDTH));
                  mode_in = csvrp_pkg::MODE_DEAD;
               end
            end else if (crlf) begin
               mode_in = csvrp_pkg::MODE_TRAIL;
            end else begin
               push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                          csvrp_pkg::ERR_WIDTH));
               mode_in = csvrp_pkg::MODE_DEAD;
            end
         end

         // Line end: close the open field, then clear the line state
         if (req_payload.line_last) begin
            more = ({1'b0, col_in} + 7'd1) < eff_count;
            unique case (mode_in)
               csvrp_pkg::MODE_INT: begin
                  fin = int_fin(ne_in, bad_in, ph_in, neg_in, ovf_in, mag_in);
                  if (!fin.ok) begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                                fin.err));
                  end else begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_INT, col_in, 8'd0,
                                                fin.val, 3'd0));
                     if (more) begin
                        push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0,
                                                   64'd0, csvrp_pkg::ERR_WIDTH));
                     end else begin
                        push(res0, res1, res_n, mk(csvrp_pkg::KIND_DONE, '0, 8'd0,
                                                   64'd0, 3'd0));
                     end
                  end
               end
               csvrp_pkg::MODE_TOPEN: begin
                  push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                             csvrp_pkg::ERR_UNQUOTED));
               end
               csvrp_pkg::MODE_TIN: begin
                  push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                             csvrp_pkg::ERR_UNTERM));
               end
               csvrp_pkg::MODE_TQUOTE: begin
                  push(res0, res1, res_n, mk(csvrp_pkg::KIND_TEND, col_in, 8'd0, 64'd0,
                                             3'd0));
                  if (more) begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_ERR, col_in, 8'd0, 64'd0,
                                                csvrp_pkg::ERR_WIDTH));
                  end else begin
                     push(res0, res1, res_n, mk(csvrp_pkg::KIND_DONE, '0, 8'd0, 64'd0,
                                                3'd0));
                  end
               end
               csvrp_pkg::MODE_TRAIL: begin
                  push(res0, res1, res_n, mk(csvrp_pkg::KIND_DONE, '0, 8'd0, 64'd0,
                                             3'd0));
               end
               default: begin
               end
            endcase
            mode_in = csvrp_pkg::MODE_BLANK0;
            col_in  = '0;
            mag_in  = '0;
            neg_in  = 1'b0;
            ph_in   = csvrp_pkg::PH_WS;
            ovf_in  = 1'b0;
            bad_in  = 1'b0;
            ne_in   = 1'b0;
         end

         // Flag the last result of this byte
         if (res_n == 2'd1) begin
            res0.run_last = 1'b1;
         end else if (res_n == 2'd2) begin
            res1.run_last = 1'b1;
         end
      end
   end

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in   = wr_ptr_ff + csvrp_pkg::FIFO_PTR_W'(res_n);
      rd_ptr_in   = rd_ptr_ff + csvrp_pkg::FIFO_PTR_W'(rsp_pop);
      fifo_cnt_in = fifo_cnt_ff + csvrp_pkg::FIFO_CNT_W'(res_n) -
                    csvrp_pkg::FIFO_CNT_W'(rsp_pop);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         text_ff     <= '0;
         mode_ff     <= csvrp_pkg::MODE_BLANK0;
         col_ff      <= '0;
         mag_ff      <= '0;
         neg_ff      <= 1'b0;
         ph_ff       <= csvrp_pkg::PH_WS;
         ovf_ff      <= 1'b0;
         bad_ff      <= 1'b0;
         ne_ff       <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               csvrp_pkg::CSR_COLUMN_COUNT:   count_ff <= csr_data[csvrp_pkg::COUNT_W-1:0];
               csvrp_pkg::CSR_COLUMN_IS_TEXT: text_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         mode_ff     <= mode_in;
         col_ff      <= col_in;
         mag_ff      <= mag_in;
         neg_ff      <= neg_in;
         ph_ff       <= ph_in;
         ovf_ff      <= ovf_in;
         bad_ff      <= bad_in;
         ne_ff       <= ne_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   // Write results into the queue
   always_ff @(posedge clock) begin
      if (res_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (res_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + csvrp_pkg::FIFO_PTR_W'(1)] <= res1;
      end
   end

endmodule

/* sim/csv_typed_row_parser_top_test.sv */
// Self-checking testbench for the typed CSV row parser: stimulus, parse prediction, result check.
`timescale 1ns / 100ps

module csv_typed_row_parser_top_test;
   import csvrp_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES  = 1400;
   localparam int PHASE_BYTES   = 180;
   localparam int TIMEOUT_NS    = 10_000_000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_data    = '0;

   csv_typed_row_parser_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Schema copy and row parse state of the predictor
   logic [6:0]  cfg_columns;
   logic [63:0] cfg_text_mask;
   logic [2:0]  row_mode;
   logic [6:0]  row_col;
   logic [63:0] num_mag;
   bit          num_neg;
   logic [1:0]  num_stage;
   bit          num_over;
   bit          num_junk;
   bit          field_started;

   rsp_type     byte_results[2];
   int          byte_result_count;
   rsp_type     expected_parse_results[$];

   // Stimulus store and bookkeeping
   req_type     pending_bytes[$];
   logic [7:0]  line_buf[$];
   int          queued_total = 0;
   int          error_count  = 0;

   // Sender and receiver pacing
   bit          req_taken    = 1'b0;
   bit          sender_gaps  = 1'b0;
   bit          drain_hold   = 1'b0;
   int          burst_left   = 0;
   int          gap_left     = 0;
   int          stall_mode   = 0;
   int          stall_run    = 0;
   int          cycle_no     = 0;
   rsp_type     want;

   // ---------------------------------------------------------------- prediction

   function automatic int schema_width();
      return (int'(cfg_columns) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_columns);
   endfunction

   function automatic bit line_break(logic [7:0] b);
      return b == CHAR_CR || b == CHAR_LF;
   endfunction

   function automatic void restart_row();
      row_mode      = MODE_BLANK0;
      row_col       = '0;
      num_mag       = '0;
      num_neg       = 1'b0;
      num_stage     = PH_WS;
      num_over      = 1'b0;
      num_junk      = 1'b0;
      field_started = 1'b0;
   endfunction

   // Record one result of the current byte; at most two per byte
   function automatic void note_result(logic [2:0] kind, logic [5:0] col, logic [7:0] tb,
                                       logic [63:0] val, logic [2:0] code);
      rsp_type r;
      if (byte_result_count >= 2) return;
      r.item_kind  = kind;
      r.column     = col;
      r.text_byte  = tb;
      r.int_result = val;
      r.error_code = code;
      r.run_last   = 1'b0;
      byte_results[byte_result_count] = r;
      byte_result_count++;
   endfunction

   function automatic void abort_row(logic [2:0] code);
      note_result(KIND_ERR, row_col[5:0], 8'd0, 64'd0, code);
      row_mode = MODE_DEAD;
   endfunction

   function automatic void open_field();
      num_mag       = '0;
      num_neg       = 1'b0;
      num_stage     = PH_WS;
      num_over      = 1'b0;
      num_junk      = 1'b0;
      field_started = 1'b0;
      row_mode      = cfg_text_mask[row_col[5:0]] ? MODE_TOPEN : MODE_INT;
   endfunction

   // Finish an integer column; returns 1 when a value went out
   function automatic bit close_int_field();
      logic [63:0] v;
      if (!field_started) begin
         abort_row(ERR_EMPTY);
         return 1'b0;
      end
      if (num_junk || num_stage != PH_DIGITS) begin
         abort_row(ERR_INVALID);
         return 1'b0;
      end
      if (num_neg)
         v = (num_over || num_mag > INT_MIN_MAG) ? INT_MIN_MAG : -num_mag;
      else
         v = (num_over || num_mag > INT_MAX_MAG) ? INT_MAX_MAG : num_mag;
      note_result(KIND_INT, row_col[5:0], 8'd0, v, 3'd0);
      return 1'b1;
   endfunction

   // Byte right after a complete field: separator, line break or junk
   function automatic void next_separator(logic [7:0] b);
      if (int'(row_col) + 1 < schema_width()) begin
         if (b == CHAR_COMMA) begin
            row_col++;
            open_field();
         end else begin
            abort_row(ERR_WIDTH);
         end
      end else if (line_break(b)) begin
         row_mode = MODE_TRAIL;
      end else begin
         abort_row(ERR_WIDTH);
      end
   endfunction

   function automatic void field_step(logic [7:0] b);
      logic [63:0] d;
      case (row_mode)
         MODE_INT: begin
            if (b == CHAR_COMMA || line_break(b)) begin
               if (close_int_field()) next_separator(b);
            end else begin
               field_started = 1'b1;
               if (!num_junk) begin
                  if (num_stage == PH_WS && (b == CHAR_SPACE || b == CHAR_TAB ||
                                             b == CHAR_VT || b == CHAR_FF)) begin
                     // skip leading blanks
                  end else if (num_stage == PH_WS && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
                     num_neg   = (b == CHAR_MINUS);
                     num_stage = PH_SIGN;
                  end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
                     num_junk = 1'b1;
                  end else begin
                     num_stage = PH_DIGITS;
                     d = 64'(b - CHAR_ZERO);
                     if (!num_over) begin
                        if (num_mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                           num_over = 1'b1;
                        else
                           num_mag = num_mag * 64'd10 + d;
                     end
                  end
               end
            end
         end
         MODE_TOPEN: begin
            if (b == CHAR_QUOTE) row_mode = MODE_TIN;
            else abort_row(ERR_UNQUOTED);
         end
         MODE_TIN: begin
            if (b == CHAR_QUOTE) row_mode = MODE_TQUOTE;
            else note_result(KIND_TEXT, row_col[5:0], b, 64'd0, 3'd0);
         end
         MODE_TQUOTE: begin
            if (b == CHAR_QUOTE) begin
               note_result(KIND_TEXT, row_col[5:0], CHAR_QUOTE, 64'd0, 3'd0);
               row_mode = MODE_TIN;
            end else begin
               note_result(KIND_TEND, row_col[5:0], 8'd0, 64'd0, 3'd0);
               next_separator(b);
            end
         end
         MODE_TRAIL: begin
            if (!line_break(b)) abort_row(ERR_WIDTH);
         end
         default: begin
            // dead row: drop bytes until the line ends
         end
      endcase
   endfunction

   // Work out the results of one accepted line byte and queue them
   function automatic void parse_line_byte(req_type it);
      bit more;
      byte_result_count = 0;
      if (row_mode == MODE_BLANK0 || row_mode == MODE_BLANK1) begin
         if (line_break(it.line_byte)) begin
            row_mode = MODE_BLANK1;
         end else begin
            row_col = '0;
            if (schema_width() == 0)
               abort_row(ERR_WIDTH);
            else if (row_mode == MODE_BLANK1)
               abort_row(cfg_text_mask[0] ? ERR_UNQUOTED : ERR_EMPTY);
            else begin
               open_field();
               field_step(it.line_byte);
            end
         end
      end else begin
         field_step(it.line_byte);
      end

      // Close the line
      if (it.line_last) begin
         more = int'(row_col) + 1 < schema_width();
         case (row_mode)
            MODE_INT: begin
               if (close_int_field()) begin
                  if (more) abort_row(ERR_WIDTH);
                  else note_result(KIND_DONE, 6'd0, 8'd0, 64'd0, 3'd0);
               end
            end
            MODE_TOPEN: abort_row(ERR_UNQUOTED);
            MODE_TIN:   abort_row(ERR_UNTERM);
            MODE_TQUOTE: begin
               note_result(KIND_TEND, row_col[5:0], 8'd0, 64'd0, 3'd0);
               if (more) abort_row(ERR_WIDTH);
               else note_result(KIND_DONE, 6'd0, 8'd0, 64'd0, 3'd0);
            end
            MODE_TRAIL: note_result(KIND_DONE, 6'd0, 8'd0, 64'd0, 3'd0);
            default: begin
               // blank line or dead row: nothing to add
            end
         endcase
         restart_row();
      end

      if (byte_result_count > 0) byte_results[byte_result_count - 1].run_last = 1'b1;
      for (int i = 0; i < byte_result_count; i++)
         expected_parse_results.push_back(byte_results[i]);
   endfunction

   // ---------------------------------------------------------------- line building

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   // Move the line under construction to the send queue, flag on its last byte
   function automatic void queue_line();
      req_type it;
      for (int i = 0; i < line_buf.size(); i++) begin
         it.line_byte = line_buf[i];
         it.line_last = (i == line_buf.size() - 1);
         pending_bytes.push_back(it);
      end
      queued_total += line_buf.size();
      line_buf.delete();
   endfunction

   // Byte biased toward the characters the parser cares about
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return CHAR_COMMA;
         1: return CHAR_QUOTE;
         2: return CHAR_CR;
         3: return CHAR_LF;
         4: return CHAR_ZERO + 8'($urandom_range(0, 9));
         5: return CHAR_MINUS;
         6: return CHAR_SPACE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void put_int_field();
      int lead;
      int digits;
      int form;
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (lead) begin
         case ($urandom_range(0, 3))
            0: line_buf.push_back(CHAR_SPACE);
            1: line_buf.push_back(CHAR_TAB);
            2: line_buf.push_back(CHAR_VT);
            default: line_buf.push_back(CHAR_FF);
         endcase
      end
      case ($urandom_range(0, 3))
         0: line_buf.push_back(CHAR_MINUS);
         1: line_buf.push_back(CHAR_PLUS);
         default: begin
            // unsigned
         end
      endcase
      form   = $urandom_range(0, 11);
      digits = 0;
      case (form)
         6: begin
            // values around the 64-bit limits
            case ($urandom_range(0, 5))
               0: put_text("9223372036854775807");
               1: put_text("9223372036854775808");
               2: put_text("9223372036854775809");
               3: put_text("18446744073709551615");
               4: put_text("18446744073709551616");
               default: put_text("000000000000000000000000042");
            endcase
         end
         7, 8:  digits = $urandom_range(15, 22);
         9:     digits = 1;
         10:    digits = 0;
         11:    digits = $urandom_range(1, 3);
         default: digits = $urandom_range(1, 6);
      endcase
      repeat (digits) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if (form == 11)
         line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_text_field();
      logic [7:0] c;
      line_buf.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         c = $urandom_range(0, 1) ? pick_byte() : 8'($urandom_range(32, 126));
         line_buf.push_back(c);
         if (c == CHAR_QUOTE) line_buf.push_back(CHAR_QUOTE);
      end
      line_buf.push_back(CHAR_QUOTE);
   endfunction

   // Row for the current schema (integer fields may be empty or end in a stray byte) with a random line ending
   function automatic void build_row();
      for (int c = 0; c < schema_width(); c++) begin
         if (c > 0) line_buf.push_back(CHAR_COMMA);
         if (cfg_text_mask[c]) put_text_field();
         else put_int_field();
      end
      case ($urandom_range(0, 4))
         0: begin
            // no line break
         end
         1: line_buf.push_back(CHAR_LF);
         2: begin
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
         end
         3: line_buf.push_back(CHAR_CR);
         default: begin
            line_buf.push_back(CHAR_LF);
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
         end
      endcase
      if (line_buf.size() == 0) line_buf.push_back(CHAR_LF);
   endfunction

   // Break a built row: overwrite, drop, insert or cut short
   function automatic void damage_row();
      int pos;
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 3))
         0: line_buf[pos] = pick_byte();
         1: line_buf.delete(pos);
         2: line_buf.insert(pos, pick_byte());
         default: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
      endcase
      if (line_buf.size() == 0) line_buf.push_back(pick_byte());
   endfunction

   // Queue a mix of good rows, broken rows and noise for one schema
   function automatic void fill_phase(int budget);
      int goal;
      goal = queued_total + budget;
      while (queued_total < goal) begin
         case ($urandom_range(0, 9))
            0: begin
               if ($urandom_range(0, 2) == 0)
                  line_buf.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
               repeat ($urandom_range(1, 10)) line_buf.push_back(pick_byte());
            end
            1, 2: begin
               build_row();
               damage_row();
            end
            default: build_row();
         endcase
         queue_line();
      end
   endfunction

   // ---------------------------------------------------------------- register access

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_COLUMN_COUNT) cfg_columns = value[6:0];
      else cfg_text_mask = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Column count goes out with random upper bits, which the block ignores
   task automatic apply_schema(input int cols, input logic [63:0] mask);
      logic [63:0] count_word;
      count_word      = {$urandom, $urandom};
      count_word[6:0] = cols[6:0];
      write_register(CSR_COLUMN_COUNT, count_word);
      write_register(CSR_COLUMN_IS_TEXT, mask);
   endtask

   // Wait for all bytes to go in, all results to come out, then settle
   task automatic wait_until_idle();
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_parse_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   // Sample byte acceptance and predict its results
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) parse_line_byte(req_payload);
   end

   // Offer bytes in bursts; hold a stalled item, pause for gaps and drains
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (drain_hold) begin
            if (expected_parse_results.size() == 0) drain_hold = 1'b0;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_payload <= pending_bytes.pop_front();
            req_valid   <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 32);
               gap_left   = sender_gaps ? $urandom_range(1, 8) : 0;
               drain_hold = ($urandom_range(0, 11) == 0);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: switch between free, light, heavy and periodic stalls
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(16, 160);
      end else begin
         stall_run--;
      end
      cycle_no++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cycle_no % 5 < 2);
      endcase
   end

   // ---------------------------------------------------------------- monitor

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_parse_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: kind %0d col %0d byte %h int %0d err %0d last %b",
                     $time, rsp_payload.item_kind, rsp_payload.column,
                     rsp_payload.text_byte, rsp_payload.int_result,
                     rsp_payload.error_code, rsp_payload.run_last);
         end else begin
            want = expected_parse_results.pop_front();
            if (rsp_payload.item_kind  !== want.item_kind  ||
                rsp_payload.column     !== want.column     ||
                rsp_payload.text_byte  !== want.text_byte  ||
                rsp_payload.int_result !== want.int_result ||
                rsp_payload.error_code !== want.error_code ||
                rsp_payload.run_last   !== want.run_last) begin
               error_count++;
               $display("%0t: result mismatch", $time,
                        "\n   expected kind %0d col %0d byte %h int %0d err %0d last %b",
                        want.item_kind, want.column, want.text_byte,
                        want.int_result, want.error_code, want.run_last,
                        "\n   actual   kind %0d col %0d byte %h int %0d err %0d last %b",
                        rsp_payload.item_kind, rsp_payload.column,
                        rsp_payload.text_byte, rsp_payload.int_result,
                        rsp_payload.error_code, rsp_payload.run_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int phase;
      int cols;
      int random_start;
      logic [63:0] mask;

      restart_row();
      cfg_columns   = '0;
      cfg_text_mask = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Text column then integer column
      apply_schema(2, 64'h1);
      put_text("\"a\"\"");
      line_buf.push_back(8'hFF);
      put_text("\",-7");
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      queue_line();
      // blank prefix then data on a text column
      line_buf.push_back(CHAR_LF);
      line_buf.push_back(CHAR_QUOTE);
      queue_line();
      // missing separator, then ignored bytes
      put_text("\"x\"0,1");
      queue_line();
      // bad integer reported at the end of the field
      put_text("\"\",5x");
      queue_line();
      // unterminated text holding a NUL
      line_buf.push_back(CHAR_QUOTE);
      line_buf.push_back(8'h00);
      queue_line();
      // line ends where the separator belongs
      put_text("\"q\"");
      queue_line();
      wait_until_idle();

      // Integer column then text column, top mask bit set
      apply_schema(2, 64'h8000_0000_0000_0002);
      put_text("5,");
      queue_line();
      wait_until_idle();

      // Single integer column
      apply_schema(1, 64'h0);
      line_buf.push_back(CHAR_CR);
      put_text("7");
      queue_line();
      put_text(",");
      queue_line();
      put_text("1");
      line_buf.push_back(CHAR_CR);
      put_text("9");
      queue_line();
      put_text("-0");
      queue_line();
      wait_until_idle();

      // No columns at all
      apply_schema(0, '1);
      put_text("a");
      queue_line();
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      queue_line();
      wait_until_idle();

      // Random rows over a rotation of schemas, extremes included
      random_start = queued_total;
      for (phase = 0; queued_total - random_start < RANDOM_BYTES; phase++) begin
         mask = {$urandom, $urandom};
         case (phase % 7)
            0: cols = $urandom_range(2, 6);
            1: begin
               cols = 1;
               mask = '0;
            end
            2: begin
               cols = MAX_COLUMNS;
               mask = '1;
            end
            3: cols = $urandom_range(65, 127);
            4: cols = 0;
            5: begin
               cols = MAX_COLUMNS;
               mask = '0;
            end
            default: cols = $urandom_range(1, 12);
         endcase
         sender_gaps = ($urandom_range(0, 3) != 0);
         apply_schema(cols, mask);
         fill_phase(PHASE_BYTES);
         wait_until_idle();
      end

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* csv_typed_row_parser_top.f */
hw/rtl/csvrp_pkg.sv
hw/rtl/csv_typed_row_parser_top.sv
sim/csv_typed_row_parser_top_test.sv
